@@ rtl/core/biquad_pkg.sv @@
// ----------------------------------------------------------------------------
// biquad_pkg
// shared widths, defaults and register indexes of the biquad low-pass filter
// ----------------------------------------------------------------------------
package biquad_pkg;

  // default parameter values
  localparam int SAMPLE_SHIFT   = 4;
  localparam int COEF_FRAC_BITS = 13;

  // fixed field widths
  localparam int ADC_W   = 12;
  localparam int COEF_W  = 16;
  localparam int OUT_W   = 24;
  localparam int PORT_W  = 8;
  localparam int SCALE_FRAC_BITS = 16;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_COEF_B0   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_B1   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_B2   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_A1   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_A2   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_OUT_SCALE = 3'd5;

  // register reset values
  localparam logic [COEF_W-1:0] RST_COEF_B0   = 16'd8192;
  localparam logic [COEF_W-1:0] RST_COEF_B1   = 16'd16384;
  localparam logic [COEF_W-1:0] RST_COEF_B2   = 16'd8192;
  localparam logic [COEF_W-1:0] RST_COEF_A1   = 16'hCA2B;  // -13781
  localparam logic [COEF_W-1:0] RST_COEF_A2   = 16'd5949;
  localparam logic [COEF_W-1:0] RST_OUT_SCALE = 16'd655;

endpackage

@@ rtl/core/biquad_lowpass_filter.sv @@
// ----------------------------------------------------------------------------
// biquad_lowpass_filter
// second-order direct form I low-pass filter on one shared multiplier
// ----------------------------------------------------------------------------
// sequence: an input transfer passes 6 mac steps, quantize, scale multiply
//   and port rounding, and waits there while the output register is still full
// input: taken only in idle, so not before the last result is written out;
//   the five filter products and the scale product share the single multiplier
// reset: rst (synchronous) restores default coefficients and scale, clears the
//   sample and output delay lines and empties the output register
// ----------------------------------------------------------------------------
module biquad_lowpass_filter #(
  parameter int SAMPLE_SHIFT   = biquad_pkg::SAMPLE_SHIFT,
  parameter int COEF_FRAC_BITS = biquad_pkg::COEF_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst,
  // configuration writes
  input  logic                              cfg_wr_en,
  input  logic [biquad_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [biquad_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [11:0] adc_reading, [15:12] zero
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [23:0] filtered_value, [31:24] port_byte
);

  // sample width after the converter shift
  localparam int SMP_W = biquad_pkg::ADC_W - SAMPLE_SHIFT;
  // multiplier operands: 17-bit signed coefficient/scale, 25-bit signed data
  localparam int MA_W  = biquad_pkg::COEF_W + 1;
  localparam int MB_W  = biquad_pkg::OUT_W + 1;
  localparam int PR_W  = MA_W + MB_W;
  localparam int ACC_W = PR_W + 2;

  localparam logic signed [ACC_W-1:0] Q_BIAS  = ACC_W'((64'd1 << COEF_FRAC_BITS) - 64'd1);
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'd8388607);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(64'd8388608);
  localparam logic signed [PR_W-1:0]  P_BIAS  =
    PR_W'((64'd1 << biquad_pkg::SCALE_FRAC_BITS) - 64'd1);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MAC   = 3'd1;
  localparam logic [2:0] ST_QUANT = 3'd2;
  localparam logic [2:0] ST_PMUL  = 3'd3;
  localparam logic [2:0] ST_PORT  = 3'd4;

  // mac step indexes
  localparam logic [2:0] STEP_B0   = 3'd0;
  localparam logic [2:0] STEP_B1   = 3'd1;
  localparam logic [2:0] STEP_B2   = 3'd2;
  localparam logic [2:0] STEP_A1   = 3'd3;
  localparam logic [2:0] STEP_A2   = 3'd4;
  localparam logic [2:0] STEP_LAST = 3'd5;

  // configuration registers
  logic [biquad_pkg::COEF_W-1:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  logic [biquad_pkg::COEF_W-1:0] out_scale;

  // filter state
  logic [SMP_W-1:0] sample_cur, sample_prev, sample_older;
  logic signed [biquad_pkg::OUT_W-1:0] output_prev, output_older, y_res;

  // datapath
  logic [2:0] state;
  logic [2:0] step;
  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [PR_W-1:0]  prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_adj;
  logic signed [ACC_W-1:0] quo;
  logic signed [biquad_pkg::OUT_W-1:0] y_sat;
  logic signed [PR_W-1:0]  prod_adj;
  logic [biquad_pkg::PORT_W-1:0] port_byte;
  logic out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // configuration register writes, out-of-range indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0   <= biquad_pkg::RST_COEF_B0;
      coef_b1   <= biquad_pkg::RST_COEF_B1;
      coef_b2   <= biquad_pkg::RST_COEF_B2;
      coef_a1   <= biquad_pkg::RST_COEF_A1;
      coef_a2   <= biquad_pkg::RST_COEF_A2;
      out_scale <= biquad_pkg::RST_OUT_SCALE;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        biquad_pkg::REG_COEF_B0:   coef_b0   <= cfg_wdata;
        biquad_pkg::REG_COEF_B1:   coef_b1   <= cfg_wdata;
        biquad_pkg::REG_COEF_B2:   coef_b2   <= cfg_wdata;
        biquad_pkg::REG_COEF_A1:   coef_a1   <= cfg_wdata;
        biquad_pkg::REG_COEF_A2:   coef_a2   <= cfg_wdata;
        biquad_pkg::REG_OUT_SCALE: out_scale <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // shared multiplier operand select; feedback terms use negated coefficients
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == ST_PMUL) begin
      mul_a = $signed({1'b0, out_scale});
      mul_b = MB_W'(y_res);
    end else begin
      case (step)
        STEP_B0: begin
          mul_a = $signed({coef_b0[biquad_pkg::COEF_W-1], coef_b0});
          mul_b = $signed(MB_W'(sample_cur));
        end
        STEP_B1: begin
          mul_a = $signed({coef_b1[biquad_pkg::COEF_W-1], coef_b1});
          mul_b = $signed(MB_W'(sample_prev));
        end
        STEP_B2: begin
          mul_a = $signed({coef_b2[biquad_pkg::COEF_W-1], coef_b2});
          mul_b = $signed(MB_W'(sample_older));
        end
        STEP_A1: begin
          mul_a = -$signed({coef_a1[biquad_pkg::COEF_W-1], coef_a1});
          mul_b = MB_W'(output_prev);
        end
        STEP_A2: begin
          mul_a = -$signed({coef_a2[biquad_pkg::COEF_W-1], coef_a2});
          mul_b = MB_W'(output_older);
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  // quantize: divide by 2^frac truncating toward zero, then saturate
  always_comb begin
    acc_adj = acc + (acc[ACC_W-1] ? Q_BIAS : '0);
    quo     = acc_adj >>> COEF_FRAC_BITS;
    if (quo > SAT_MAX) begin
      y_sat = biquad_pkg::OUT_W'(SAT_MAX);
    end else if (quo < SAT_MIN) begin
      y_sat = biquad_pkg::OUT_W'(SAT_MIN);
    end else begin
      y_sat = biquad_pkg::OUT_W'(quo);
    end
  end

  // port byte: scale product over 2^16 toward zero, low bits kept
  always_comb begin
    prod_adj  = prod + (prod[PR_W-1] ? P_BIAS : '0);
    port_byte = prod_adj[biquad_pkg::SCALE_FRAC_BITS +: biquad_pkg::PORT_W];
  end

  // product register, free running
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // sequencer, accumulator and delay lines
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      step         <= STEP_B0;
      m_tvalid     <= 1'b0;
      sample_prev  <= '0;
      sample_older <= '0;
      output_prev  <= '0;
      output_older <= '0;
    end else begin
      // a result transfer empties the output register unless a new one lands
      if (m_tready && state != ST_PORT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            sample_cur <= SMP_W'(s_tdata[biquad_pkg::ADC_W-1:0] >> SAMPLE_SHIFT);
            acc        <= '0;
            step       <= STEP_B0;
            state      <= ST_MAC;
          end
        end
        ST_MAC: begin
          // product of the previous step lands in the accumulator
          if (step != STEP_B0) begin
            acc <= acc + ACC_W'(prod);
          end
          if (step == STEP_LAST) begin
            state <= ST_QUANT;
          end else begin
            step <= step + 3'd1;
          end
        end
        ST_QUANT: begin
          y_res <= y_sat;
          step  <= STEP_B0;
          state <= ST_PMUL;
        end
        ST_PMUL: begin
          state <= ST_PORT;
        end
        ST_PORT: begin
          // wait for the output register to drain before the transfer
          if (out_free) begin
            m_tdata      <= {port_byte, y_res};
            m_tvalid     <= 1'b1;
            sample_older <= sample_prev;
            sample_prev  <= sample_cur;
            output_older <= output_prev;
            output_prev  <= y_res;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
